[rtl/core/tcw_pkg.sv]
// Shared types, widths and codes of the text console writer.
`default_nettype none
package tcw_pkg;

  localparam int ROWS_DEF = 25;
  localparam int COLS_DEF = 80;

  localparam int CMD_W    = 3;
  localparam int ROW_W    = 5;
  localparam int COL_W    = 7;
  localparam int GLYPH_W  = 8;
  localparam int COLOUR_W = 4;
  localparam int ATTR_W   = 8;
  localparam int CELL_W   = GLYPH_W + ATTR_W;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CURSOR     = 1'd1;

  localparam logic [GLYPH_W-1:0]  NEWLINE_GLYPH    = 8'd10;
  localparam logic [GLYPH_W-1:0]  CURSOR_GLYPH_RST = 8'd95;
  localparam logic [COLOUR_W-1:0] CURSOR_FG        = 4'hF;

  typedef enum logic [CMD_W-1:0] {
    CMD_PRINT     = 3'd0,
    CMD_NEWLINE   = 3'd1,
    CMD_BACKSPACE = 3'd2,
    CMD_SET_CUR   = 3'd3,
    CMD_WRITE     = 3'd4,
    CMD_SHOW_CUR  = 3'd5,
    CMD_CLEAR     = 3'd6,
    CMD_READ      = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_CLEAR,
    S_SCR_RD,
    S_SCR_WR,
    S_BLANK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic col_last;
    logic row_last;
    logic row_penult;
  } step_flags_t;

endpackage
`default_nettype wire

[rtl/core/tcw_if.sv]
// Command and result channel interfaces of the text console writer.
`default_nettype none
interface tcw_cmd_if;
  import tcw_pkg::*;
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [ROW_W-1:0]    row;
  logic [COL_W-1:0]    col;
  logic [GLYPH_W-1:0]  glyph;
  logic [COLOUR_W-1:0] fg_colour;
  logic [COLOUR_W-1:0] bg_colour;

  modport source (output valid, command, row, col, glyph, fg_colour, bg_colour,
                  input ready);
  modport sink (input valid, command, row, col, glyph, fg_colour, bg_colour,
                output ready);
endinterface

interface tcw_res_if;
  import tcw_pkg::*;
  logic               valid;
  logic               ready;
  logic [GLYPH_W-1:0] read_glyph;
  logic [ATTR_W-1:0]  read_attribute;
  logic [ROW_W-1:0]   cursor_row;
  logic [COL_W-1:0]   cursor_col;

  modport source (output valid, read_glyph, read_attribute, cursor_row, cursor_col,
                  input ready);
  modport sink (input valid, read_glyph, read_attribute, cursor_row, cursor_col,
                output ready);
endinterface
`default_nettype wire

[rtl/core/tcw_screen_ram.sv]
// Screen cell memory: one write port and one registered read port.
`default_nettype none
module tcw_screen_ram #(
  parameter int AW = 12,
  parameter int DW = 16
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[rtl/core/tcw_step_unit.sv]
// Position stepper shared by cursor moves and screen walks.
`default_nettype none
module tcw_step_unit #(
  parameter int ROWS = tcw_pkg::ROWS_DEF,
  parameter int COLS = tcw_pkg::COLS_DEF,
  parameter int RW   = $clog2(ROWS),
  parameter int CW   = $clog2(COLS)
) (
  input  wire logic [RW-1:0]         pos_row,
  input  wire logic [CW-1:0]         pos_col,
  output logic      [RW-1:0]         nxt_row,
  output logic      [CW-1:0]         nxt_col,
  output tcw_pkg::step_flags_t       flags
);
  import tcw_pkg::*;

  always_comb begin
    flags.col_last   = (pos_col == CW'(COLS - 1));
    flags.row_last   = (pos_row == RW'(ROWS - 1));
    flags.row_penult = (pos_row == RW'(ROWS - 2));
    // Only used below the last row, so the increment never overflows.
    nxt_row = pos_row + RW'(1);
    nxt_col = flags.col_last ? '0 : pos_col + CW'(1);
  end

endmodule
`default_nettype wire

[rtl/core/tcw_seq.sv]
// Command sequencer: cursor, screen walks for clear and scroll, result register.
`default_nettype none
module tcw_seq #(
  parameter int ROWS = tcw_pkg::ROWS_DEF,
  parameter int COLS = tcw_pkg::COLS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [tcw_pkg::CMD_W-1:0]       in_command,
  input  wire logic [tcw_pkg::ROW_W-1:0]       in_row,
  input  wire logic [tcw_pkg::COL_W-1:0]       in_col,
  input  wire logic [tcw_pkg::GLYPH_W-1:0]     in_glyph,
  input  wire logic [tcw_pkg::COLOUR_W-1:0]    in_fg_colour,
  input  wire logic [tcw_pkg::COLOUR_W-1:0]    in_bg_colour,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [tcw_pkg::GLYPH_W-1:0]     out_read_glyph,
  output logic      [tcw_pkg::ATTR_W-1:0]      out_read_attribute,
  output logic      [tcw_pkg::ROW_W-1:0]       out_cursor_row,
  output logic      [tcw_pkg::COL_W-1:0]       out_cursor_col,
  input  wire logic [tcw_pkg::COLOUR_W-1:0]    bg_i,
  input  wire logic [tcw_pkg::GLYPH_W-1:0]     cursor_glyph_i
);
  import tcw_pkg::*;

  localparam int RW = $clog2(ROWS);
  localparam int CW = $clog2(COLS);
  localparam int AW = RW + CW;

  state_t              state_r, state_nxt;
  logic                init_r, init_nxt;
  cmd_t                cmd_r, cmd_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic [COL_W-1:0]    col_r, col_nxt;
  logic [GLYPH_W-1:0]  glyph_r, glyph_nxt;
  logic [COLOUR_W-1:0] fg_r, fg_nxt;
  logic [COLOUR_W-1:0] bgc_r, bgc_nxt;
  logic [RW-1:0]       cur_row_r, cur_row_nxt;
  logic [CW-1:0]       cur_col_r, cur_col_nxt;
  logic [RW-1:0]       wrow_r, wrow_nxt;
  logic [CW-1:0]       wcol_r, wcol_nxt;
  logic                rd_hit_r, rd_hit_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [GLYPH_W-1:0]  out_glyph_r, out_glyph_nxt;
  logic [ATTR_W-1:0]   out_attr_r, out_attr_nxt;
  logic [ROW_W-1:0]    out_crow_r, out_crow_nxt;
  logic [COL_W-1:0]    out_ccol_r, out_ccol_nxt;

  logic                walking;
  logic [RW-1:0]       pos_row, nxt_row;
  logic [CW-1:0]       pos_col, nxt_col;
  step_flags_t         flags;

  logic                we, re;
  logic [AW-1:0]       waddr, raddr;
  logic [CELL_W-1:0]   wdata, rdata;

  logic                row_ok, col_ok;
  logic [CELL_W-1:0]   blank_cell;

  assign walking = (state_r == S_CLEAR) || (state_r == S_SCR_RD) ||
                   (state_r == S_SCR_WR) || (state_r == S_BLANK);
  assign pos_row = walking ? wrow_r : cur_row_r;
  assign pos_col = walking ? wcol_r : cur_col_r;

  tcw_step_unit #(.ROWS(ROWS), .COLS(COLS), .RW(RW), .CW(CW)) u_step (
    .pos_row (pos_row),
    .pos_col (pos_col),
    .nxt_row (nxt_row),
    .nxt_col (nxt_col),
    .flags   (flags)
  );

  tcw_screen_ram #(.AW(AW), .DW(CELL_W)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign row_ok = (32'(row_r) < ROWS);
  assign col_ok = (32'(col_r) < COLS);
  // The power-up pass zeroes the store; later blanks use the background colour.
  assign blank_cell = init_r ? '0 : {bg_i, bg_i, GLYPH_W'(0)};

  assign in_ready           = (state_r == S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_read_glyph     = out_glyph_r;
  assign out_read_attribute = out_attr_r;
  // The cursor is captured with the result, since the next command may move it
  // while this result still waits for its transfer.
  assign out_cursor_row     = out_crow_r;
  assign out_cursor_col     = out_ccol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      init_r      <= 1'b1;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      wrow_r      <= '0;
      wcol_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_r      <= init_nxt;
      cur_row_r   <= cur_row_nxt;
      cur_col_r   <= cur_col_nxt;
      wrow_r      <= wrow_nxt;
      wcol_r      <= wcol_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    row_r       <= row_nxt;
    col_r       <= col_nxt;
    glyph_r     <= glyph_nxt;
    fg_r        <= fg_nxt;
    bgc_r       <= bgc_nxt;
    rd_hit_r    <= rd_hit_nxt;
    out_glyph_r <= out_glyph_nxt;
    out_attr_r  <= out_attr_nxt;
    out_crow_r  <= out_crow_nxt;
    out_ccol_r  <= out_ccol_nxt;
  end

  always_comb begin
    logic newline;
    newline       = 1'b0;
    state_nxt     = state_r;
    init_nxt      = init_r;
    cmd_nxt       = cmd_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    glyph_nxt     = glyph_r;
    fg_nxt        = fg_r;
    bgc_nxt       = bgc_r;
    cur_row_nxt   = cur_row_r;
    cur_col_nxt   = cur_col_r;
    wrow_nxt      = wrow_r;
    wcol_nxt      = wcol_r;
    rd_hit_nxt    = rd_hit_r;
    out_valid_nxt = out_valid_r;
    out_glyph_nxt = out_glyph_r;
    out_attr_nxt  = out_attr_r;
    out_crow_nxt  = out_crow_r;
    out_ccol_nxt  = out_ccol_r;
    we            = 1'b0;
    waddr         = {cur_row_r, cur_col_r};
    wdata         = blank_cell;
    re            = 1'b0;
    raddr         = {RW'(row_r), CW'(col_r)};

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = cmd_t'(in_command);
          row_nxt   = in_row;
          col_nxt   = in_col;
          glyph_nxt = in_glyph;
          fg_nxt    = in_fg_colour;
          bgc_nxt   = in_bg_colour;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt  = S_DONE;
        rd_hit_nxt = 1'b0;
        case (cmd_r)
          CMD_PRINT: begin
            if (glyph_r == NEWLINE_GLYPH) begin
              newline = 1'b1;
            end else begin
              we    = 1'b1;
              wdata = {bgc_r, fg_r, glyph_r};
              if (flags.col_last) begin
                newline = 1'b1;
              end else begin
                cur_col_nxt = nxt_col;
              end
            end
          end
          CMD_NEWLINE: begin
            newline = 1'b1;
          end
          CMD_BACKSPACE: begin
            if (cur_col_r != '0) begin
              we          = 1'b1;
              waddr       = {cur_row_r, cur_col_r - CW'(1)};
              cur_col_nxt = cur_col_r - CW'(1);
            end else if (cur_row_r != '0) begin
              cur_row_nxt = cur_row_r - RW'(1);
              cur_col_nxt = CW'(COLS - 1);
            end
          end
          CMD_SET_CUR: begin
            cur_row_nxt = row_ok ? RW'(row_r) : RW'(ROWS - 1);
            cur_col_nxt = col_ok ? CW'(col_r) : CW'(COLS - 1);
          end
          CMD_WRITE: begin
            we    = row_ok && col_ok;
            waddr = {RW'(row_r), CW'(col_r)};
            wdata = {bgc_r, fg_r, glyph_r};
          end
          CMD_SHOW_CUR: begin
            we    = 1'b1;
            wdata = {1'b1, bg_i[COLOUR_W-2:0], CURSOR_FG, cursor_glyph_i};
          end
          CMD_CLEAR: begin
            cur_row_nxt = '0;
            cur_col_nxt = '0;
            wrow_nxt    = '0;
            wcol_nxt    = '0;
            state_nxt   = S_CLEAR;
          end
          CMD_READ: begin
            re         = row_ok && col_ok;
            rd_hit_nxt = row_ok && col_ok;
          end
          default: begin
          end
        endcase
        if (newline) begin
          cur_col_nxt = '0;
          if (flags.row_last) begin
            // Bottom row: scroll the screen up, the cursor stays on the last row.
            wrow_nxt  = '0;
            wcol_nxt  = '0;
            state_nxt = S_SCR_RD;
          end else begin
            cur_row_nxt = nxt_row;
          end
        end
      end
      S_CLEAR: begin
        we    = 1'b1;
        waddr = {wrow_r, wcol_r};
        wcol_nxt = nxt_col;
        if (flags.col_last) begin
          if (flags.row_last) begin
            init_nxt  = 1'b0;
            state_nxt = init_r ? S_IDLE : S_DONE;
          end else begin
            wrow_nxt = nxt_row;
          end
        end
      end
      S_SCR_RD: begin
        re        = 1'b1;
        raddr     = {nxt_row, wcol_r};
        state_nxt = S_SCR_WR;
      end
      S_SCR_WR: begin
        we        = 1'b1;
        waddr     = {wrow_r, wcol_r};
        wdata     = rdata;
        wcol_nxt  = nxt_col;
        state_nxt = S_SCR_RD;
        if (flags.col_last) begin
          wrow_nxt = nxt_row;
          if (flags.row_penult) begin
            state_nxt = S_BLANK;
          end
        end
      end
      S_BLANK: begin
        we       = 1'b1;
        waddr    = {wrow_r, wcol_r};
        wcol_nxt = nxt_col;
        if (flags.col_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_crow_nxt  = ROW_W'(cur_row_r);
          out_ccol_nxt  = COL_W'(cur_col_r);
          if ((cmd_r == CMD_READ) && rd_hit_r) begin
            out_glyph_nxt = rdata[GLYPH_W-1:0];
            out_attr_nxt  = rdata[CELL_W-1:GLYPH_W];
          end else begin
            out_glyph_nxt = '0;
            out_attr_nxt  = '0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[rtl/core/text_console_writer_top.sv]
// Top level of the text console writer: channels, configuration registers, sequencer.
// An ordinary command passes through the execute and done states; the done state
// registers its result once the result register is free. A new command is taken
// only in the idle state. Scroll and clear add a screen walk before the done state.
// Reset is synchronous, active low; afterwards a clearing pass zeroes the screen
// before the first command is taken.
`default_nettype none
module text_console_writer_top #(
  parameter int ROWS = tcw_pkg::ROWS_DEF,
  parameter int COLS = tcw_pkg::COLS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  tcw_cmd_if.sink                                in_ch,
  tcw_res_if.source                              out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [tcw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [tcw_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import tcw_pkg::*;

  logic [COLOUR_W-1:0] bg_r;
  logic [GLYPH_W-1:0]  cursor_glyph_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bg_r           <= '0;
      cursor_glyph_r <= CURSOR_GLYPH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BACKGROUND: bg_r           <= cfg_data[COLOUR_W-1:0];
        CFG_CURSOR:     cursor_glyph_r <= cfg_data[GLYPH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  tcw_seq #(.ROWS(ROWS), .COLS(COLS)) u_seq (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_ch.valid),
    .in_ready           (in_ch.ready),
    .in_command         (in_ch.command),
    .in_row             (in_ch.row),
    .in_col             (in_ch.col),
    .in_glyph           (in_ch.glyph),
    .in_fg_colour       (in_ch.fg_colour),
    .in_bg_colour       (in_ch.bg_colour),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_read_glyph     (out_ch.read_glyph),
    .out_read_attribute (out_ch.read_attribute),
    .out_cursor_row     (out_ch.cursor_row),
    .out_cursor_col     (out_ch.cursor_col),
    .bg_i               (bg_r),
    .cursor_glyph_i     (cursor_glyph_r)
  );

endmodule
`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench of the text console writer with a shadow screen and cursor.
module tb_top;
  import tcw_pkg::*;

  localparam int NROWS = ROWS_DEF;
  localparam int NCOLS = COLS_DEF;
  localparam int NCELLS = NROWS * NCOLS;
  localparam int LIMIT_CYCLES = 20_000_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int ITEMS_PER_PHASE = 375;
  localparam logic [ATTR_W-1:0] BLINK_BIT = 8'h80;

  typedef struct packed {
    cmd_t                command;
    logic [ROW_W-1:0]    row;
    logic [COL_W-1:0]    col;
    logic [GLYPH_W-1:0]  glyph;
    logic [COLOUR_W-1:0] fg_colour;
    logic [COLOUR_W-1:0] bg_colour;
  } console_cmd_t;

  typedef struct packed {
    logic [GLYPH_W-1:0] read_glyph;
    logic [ATTR_W-1:0]  read_attribute;
    logic [ROW_W-1:0]   cursor_row;
    logic [COL_W-1:0]   cursor_col;
  } console_reply_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_BACKGROUND;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  tcw_cmd_if cmd_ch ();
  tcw_res_if res_ch ();

  text_console_writer_top #(
    .ROWS (NROWS),
    .COLS (NCOLS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (cmd_ch),
    .out_ch    (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  console_cmd_t   queued_cmds[$];
  console_reply_t awaited_replies[$];
  int unsigned    sender_idle_pct = 0;
  int unsigned    receiver_stall_pct = 0;
  logic           cmd_fired = 1'b0;
  int             fail_count = 0;

  // Shadow copy of the screen, the cursor and the two registers.
  logic [CELL_W-1:0]   shadow_screen [NCELLS];
  int                  crs_row;
  int                  crs_col;
  logic [COLOUR_W-1:0] shadow_bg;
  logic [GLYPH_W-1:0]  shadow_cursor_glyph;

  function automatic logic [ATTR_W-1:0] blank_attr();
    return {shadow_bg, shadow_bg};
  endfunction

  function automatic void screen_put(int r, int c, logic [GLYPH_W-1:0] g,
                                     logic [ATTR_W-1:0] a);
    if (r < NROWS && c < NCOLS) shadow_screen[r * NCOLS + c] = {a, g};
  endfunction

  // Moving past the bottom row scrolls everything up and blanks the new last row.
  function automatic void advance_line();
    crs_col = 0;
    crs_row++;
    if (crs_row >= NROWS) begin
      for (int i = 0; i + NCOLS < NCELLS; i++) shadow_screen[i] = shadow_screen[i + NCOLS];
      for (int i = NCELLS - NCOLS; i < NCELLS; i++) shadow_screen[i] = {blank_attr(), 8'h00};
      crs_row = NROWS - 1;
    end
  endfunction

  function automatic console_reply_t shadow_execute(console_cmd_t c);
    console_reply_t r;
    r = '0;
    case (c.command)
      CMD_PRINT: begin
        if (c.glyph == NEWLINE_GLYPH) begin
          advance_line();
        end else begin
          screen_put(crs_row, crs_col, c.glyph, {c.bg_colour, c.fg_colour});
          crs_col++;
          if (crs_col >= NCOLS) advance_line();
        end
      end
      CMD_NEWLINE: advance_line();
      CMD_BACKSPACE: begin
        if (crs_col > 0) begin
          screen_put(crs_row, crs_col - 1, 8'h00, blank_attr());
          crs_col--;
        end else if (crs_row > 0) begin
          crs_row--;
          crs_col = NCOLS - 1;
        end
      end
      CMD_SET_CUR: begin
        crs_row = (int'(c.row) < NROWS) ? int'(c.row) : NROWS - 1;
        crs_col = (int'(c.col) < NCOLS) ? int'(c.col) : NCOLS - 1;
      end
      CMD_WRITE: screen_put(int'(c.row), int'(c.col), c.glyph, {c.bg_colour, c.fg_colour});
      CMD_SHOW_CUR: screen_put(crs_row, crs_col, shadow_cursor_glyph,
                               {shadow_bg, CURSOR_FG} | BLINK_BIT);
      CMD_CLEAR: begin
        for (int i = 0; i < NCELLS; i++) shadow_screen[i] = {blank_attr(), 8'h00};
        crs_row = 0;
        crs_col = 0;
      end
      CMD_READ: begin
        if (int'(c.row) < NROWS && int'(c.col) < NCOLS)
          {r.read_attribute, r.read_glyph} = shadow_screen[int'(c.row) * NCOLS + int'(c.col)];
      end
      default: ;
    endcase
    r.cursor_row = ROW_W'(crs_row);
    r.cursor_col = COL_W'(crs_col);
    return r;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  function automatic console_cmd_t mk_cmd(cmd_t k, int r, int c, int g, int f, int b);
    console_cmd_t m;
    m.command = k;
    m.row = ROW_W'(r);
    m.col = COL_W'(c);
    m.glyph = GLYPH_W'(g);
    m.fg_colour = COLOUR_W'(f);
    m.bg_colour = COLOUR_W'(b);
    return m;
  endfunction

  // Coordinates stay on screen most of the time; the rest cover the full field range.
  function automatic console_cmd_t rand_cmd();
    console_cmd_t m;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    m.row = ($urandom_range(0, 9) == 0) ? ROW_W'($urandom_range(0, 31))
                                         : ROW_W'($urandom_range(0, NROWS - 1));
    m.col = ($urandom_range(0, 9) == 0) ? COL_W'($urandom_range(0, 127))
                                         : COL_W'($urandom_range(0, NCOLS - 1));
    m.glyph = GLYPH_W'($urandom_range(0, 255));
    m.fg_colour = COLOUR_W'($urandom_range(0, 15));
    m.bg_colour = COLOUR_W'($urandom_range(0, 15));
    if (pick < 33) m.command = CMD_PRINT;
    else if (pick < 36) m.command = CMD_NEWLINE;
    else if (pick < 44) m.command = CMD_BACKSPACE;
    else if (pick < 57) m.command = CMD_SET_CUR;
    else if (pick < 72) m.command = CMD_WRITE;
    else if (pick < 76) m.command = CMD_SHOW_CUR;
    else if (pick < 77) m.command = CMD_CLEAR;
    else m.command = CMD_READ;
    return m;
  endfunction

  // Mostly single commands, with runs of printable text that sometimes end in a newline.
  task automatic queue_traffic(int n);
    int count;
    int run_len;
    console_cmd_t m;
    count = 0;
    while (count < n) begin
      if ($urandom_range(0, 9) == 0) begin
        run_len = $urandom_range(4, 30);
        for (int i = 0; i < run_len; i++) begin
          m = rand_cmd();
          m.command = CMD_PRINT;
          m.glyph = GLYPH_W'($urandom_range(32, 126));
          if (i == run_len - 1 && $urandom_range(0, 1) == 1) m.glyph = NEWLINE_GLYPH;
          queued_cmds.push_back(m);
        end
        count += run_len;
      end else begin
        queued_cmds.push_back(rand_cmd());
        count++;
      end
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (queued_cmds.size() != 0 || cmd_ch.valid || awaited_replies.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_BACKGROUND) shadow_bg = data[COLOUR_W-1:0];
    else shadow_cursor_glyph = data;
  endtask

  // Sender: holds a command until its transfer, then picks the next one or idles.
  always @(negedge clk) begin : driver
    console_cmd_t nxt;
    if (!rst_n) begin
      cmd_ch.valid <= 1'b0;
    end else if (!cmd_ch.valid || cmd_fired) begin
      if (queued_cmds.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        nxt = queued_cmds.pop_front();
        cmd_ch.valid <= 1'b1;
        cmd_ch.command <= nxt.command;
        cmd_ch.row <= nxt.row;
        cmd_ch.col <= nxt.col;
        cmd_ch.glyph <= nxt.glyph;
        cmd_ch.fg_colour <= nxt.fg_colour;
        cmd_ch.bg_colour <= nxt.bg_colour;
      end else begin
        cmd_ch.valid <= 1'b0;
      end
    end
    res_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  always @(posedge clk) begin : monitor
    console_cmd_t   got_cmd;
    console_reply_t want;
    if (!rst_n) begin
      cmd_fired <= 1'b0;
    end else begin
      cmd_fired <= cmd_ch.valid && cmd_ch.ready;
      if (cmd_ch.valid && cmd_ch.ready) begin
        got_cmd.command = cmd_t'(cmd_ch.command);
        got_cmd.row = cmd_ch.row;
        got_cmd.col = cmd_ch.col;
        got_cmd.glyph = cmd_ch.glyph;
        got_cmd.fg_colour = cmd_ch.fg_colour;
        got_cmd.bg_colour = cmd_ch.bg_colour;
        awaited_replies.push_back(shadow_execute(got_cmd));
      end
      if (res_ch.valid && res_ch.ready) begin
        if (awaited_replies.size() == 0) begin
          $error("result transfer with no command outstanding: cursor %0d,%0d",
                 res_ch.cursor_row, res_ch.cursor_col);
          fail_count++;
        end else begin
          want = awaited_replies.pop_front();
          check_field("read_glyph", want.read_glyph, res_ch.read_glyph);
          check_field("read_attribute", want.read_attribute, res_ch.read_attribute);
          check_field("cursor_row", 8'(want.cursor_row), 8'(res_ch.cursor_row));
          check_field("cursor_col", 8'(want.cursor_col), 8'(res_ch.cursor_col));
        end
      end
    end
  end

  initial begin : watchdog
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin : sequencer
    logic [COLOUR_W-1:0] bg_set [4];
    logic [GLYPH_W-1:0]  glyph_set [4];
    int unsigned         snd_set [4];
    int unsigned         rcv_set [4];

    cmd_ch.valid = 1'b0;
    cmd_ch.command = CMD_PRINT;
    cmd_ch.row = '0;
    cmd_ch.col = '0;
    cmd_ch.glyph = '0;
    cmd_ch.fg_colour = '0;
    cmd_ch.bg_colour = '0;
    res_ch.ready = 1'b0;
    for (int i = 0; i < NCELLS; i++) shadow_screen[i] = '0;
    crs_row = 0;
    crs_col = 0;
    shadow_bg = '0;
    shadow_cursor_glyph = CURSOR_GLYPH_RST;

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, run with the reset register values and no idling.
    queued_cmds.push_back(mk_cmd(CMD_READ, 0, 0, 0, 0, 0));
    queued_cmds.push_back(mk_cmd(CMD_PRINT, 0, 0, 8'h41, 15, 0));
    queued_cmds.push_back(mk_cmd(CMD_PRINT, 31, 127, 255, 0, 15));
    queued_cmds.push_back(mk_cmd(CMD_PRINT, 0, 0, 0, 15, 15));
    queued_cmds.push_back(mk_cmd(CMD_BACKSPACE, 0, 0, 0, 0, 0));
    queued_cmds.push_back(mk_cmd(CMD_PRINT, 0, 0, NEWLINE_GLYPH, 3, 4));
    queued_cmds.push_back(mk_cmd(CMD_BACKSPACE, 0, 0, 0, 0, 0));
    queued_cmds.push_back(mk_cmd(CMD_SET_CUR, 0, 0, 0, 0, 0));
    queued_cmds.push_back(mk_cmd(CMD_BACKSPACE, 0, 0, 0, 0, 0));
    queued_cmds.push_back(mk_cmd(CMD_SET_CUR, 31, 127, 0, 0, 0));
    queued_cmds.push_back(mk_cmd(CMD_SHOW_CUR, 0, 0, 0, 0, 0));
    queued_cmds.push_back(mk_cmd(CMD_READ, NROWS - 1, NCOLS - 1, 0, 0, 0));
    queued_cmds.push_back(mk_cmd(CMD_PRINT, 0, 0, 8'h78, 7, 1));
    queued_cmds.push_back(mk_cmd(CMD_READ, NROWS - 2, NCOLS - 1, 0, 0, 0));
    queued_cmds.push_back(mk_cmd(CMD_NEWLINE, 0, 0, 0, 0, 0));
    queued_cmds.push_back(mk_cmd(CMD_WRITE, 0, 0, 8'hAA, 5, 10));
    queued_cmds.push_back(mk_cmd(CMD_WRITE, NROWS, 0, 8'h11, 1, 1));
    queued_cmds.push_back(mk_cmd(CMD_WRITE, 0, NCOLS, 8'h22, 2, 2));
    queued_cmds.push_back(mk_cmd(CMD_WRITE, 31, 127, 8'h33, 3, 3));
    queued_cmds.push_back(mk_cmd(CMD_READ, 0, 0, 0, 0, 0));
    queued_cmds.push_back(mk_cmd(CMD_READ, NROWS, 0, 0, 0, 0));
    queued_cmds.push_back(mk_cmd(CMD_READ, 0, NCOLS, 0, 0, 0));
    queued_cmds.push_back(mk_cmd(CMD_READ, 31, 127, 0, 0, 0));
    queued_cmds.push_back(mk_cmd(CMD_SET_CUR, 12, 40, 0, 0, 0));
    queued_cmds.push_back(mk_cmd(CMD_CLEAR, 0, 0, 0, 0, 0));
    queued_cmds.push_back(mk_cmd(CMD_READ, 12, 40, 0, 0, 0));
    wait_idle();

    bg_set = '{4'h0, 4'hF, COLOUR_W'($urandom_range(0, 15)), COLOUR_W'($urandom_range(0, 15))};
    glyph_set = '{8'h00, 8'hFF, GLYPH_W'($urandom_range(0, 255)),
                  GLYPH_W'($urandom_range(0, 255))};
    snd_set = '{0, 83, 0, 8};
    rcv_set = '{0, 0, 83, 8};

    for (int p = 0; p < 4; p++) begin
      // The unused upper bits of the background write carry random data.
      write_reg(CFG_BACKGROUND, {COLOUR_W'($urandom_range(0, 15)), bg_set[p]});
      write_reg(CFG_CURSOR, glyph_set[p]);
      sender_idle_pct = snd_set[p];
      receiver_stall_pct = rcv_set[p];
      if (p == 2) begin
        // The sender stops halfway and waits for every reply before going on.
        queue_traffic(ITEMS_PER_PHASE / 2);
        wait_idle();
        queue_traffic(ITEMS_PER_PHASE - ITEMS_PER_PHASE / 2);
      end else begin
        queue_traffic(ITEMS_PER_PHASE);
      end
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0 && awaited_replies.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
